// File: hw/rtl/acorn_pkg.sv
// Shared types, command codes, sequence lengths and the state update step of the engine.
package acorn_pkg;

   // Item commands
   localparam logic [2:0] CMD_IV  = 3'd0;
   localparam logic [2:0] CMD_AD  = 3'd1;
   localparam logic [2:0] CMD_ENC = 3'd2;
   localparam logic [2:0] CMD_DEC = 3'd3;
   localparam logic [2:0] CMD_FIN = 3'd4;

   // Key register indexes on the csr port
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   localparam int STATE_W = 293;

   // Byte-step counts of each phase, written as the last count value
   localparam logic [7:0] INIT_LAST    = 8'd223;  // 56 words of key and iv
   localparam logic [7:0] PAD_LAST     = 8'd31;   // 256 padding steps
   localparam logic [7:0] PAD_CA_BYTES = 8'd16;   // ca is set for the first half
   localparam logic [7:0] MIX_LAST     = 8'd79;   // 20 zero words before the tag
   localparam logic [7:0] TAG_DONE     = 8'd16;   // four tag words
   localparam logic [5:0] INIT_KEY_XOR = 6'd8;    // word that takes k0 xor one
   localparam logic [31:0] KEY_XOR_CONST = 32'h0000_0001;
   localparam logic [7:0] PAD_FIRST_BYTE = 8'h01;

   localparam logic [2:0] MAX_BYTES = 3'd4;

   typedef struct packed {
      logic       step;
      logic       clear;
      logic [7:0] x;
      logic       ca;
      logic       cb;
      logic       dec;
   } step_ctrl_type;

   typedef struct packed {
      logic        load;
      logic [31:0] word;
      logic        is_tag;
      logic        last;
   } emit_type;

   typedef struct packed {
      logic [STATE_W-1:0] st;
      logic               y;
   } step_result_type;

   function automatic logic maj3(input logic a, input logic b, input logic c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   // One state step: update the six feedback taps, form keystream and
   // nonlinear feedback, shift the state down by one.
   function automatic step_result_type acorn_step(input logic [STATE_W-1:0] s,
                                                  input logic x,
                                                  input logic ca,
                                                  input logic cb,
                                                  input logic dec);
      step_result_type    r;
      logic [STATE_W-1:0] t;
      logic s289, s230, s193, s154, s107, s61;
      logic ks, m, f;
      s289 = s[289] ^ s[235] ^ s[230];
      s230 = s[230] ^ s[196] ^ s[193];
      s193 = s[193] ^ s[160] ^ s[154];
      s154 = s[154] ^ s[111] ^ s[107];
      s107 = s[107] ^ s[66] ^ s[61];
      s61  = s[61] ^ s[23] ^ s[0];
      ks = s[12] ^ s154 ^ maj3(s[235], s61, s193) ^ ((s230 & s[111]) ^ (~s230 & s[66]));
      m  = dec ? (x ^ ks) : x;
      f  = s[0] ^ s107 ^ 1'b1 ^ maj3(s[244], s[23], s[160]) ^ (ca & s[196]) ^ (cb & ks) ^ m;
      t = s;
      t[289] = s289;
      t[230] = s230;
      t[193] = s193;
      t[154] = s154;
      t[107] = s107;
      t[61]  = s61;
      r.st = {f, t[STATE_W-1:1]};
      r.y  = x ^ ks;
      return r;
   endfunction

endpackage

// File: hw/rtl/acorn128_aead_engine.sv
// Top level of the ACORN-128 authenticated cipher engine: key registers, sequencer, core, output.
//
//  Channel | Direction | Ports                                          | Moves
//  req     | in        | req_valid/ready, command, data_word, byte_count | one command word
//  rsp     | out       | rsp_valid/ready, out_word, is_tag, last         | one result word
//  csr     | in        | csr_valid/ready, csr_index, csr_data            | one key half word
//
// The core advances eight state steps (one byte) per cycle while a phase is stepping; it holds in idle and emit.
// A data word steps its bytes; an ENC or DEC word then loads its result word, an AD word
// returns to idle. The first data word adds padding before it. The fourth iv word runs init.
// Finalize runs padding (twice if no data word came), mixing, then four tag words.
// Synchronous reset clears the state, the key registers and all control.
// Work stalls only while a finished word waits on a full output register; req is taken in idle.
module acorn128_aead_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_word,
   output logic        rsp_is_tag,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_tag_ff, rsp_tag_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_free;
   logic [7:0]  core_y;

   acorn_pkg::step_ctrl_type step_ctrl;
   acorn_pkg::emit_type      emit;

   assign csr_ready = 1'b1;

   // Write the key halves
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            acorn_pkg::REG_KEY_LOW:  key_low_in  = csr_data;
            acorn_pkg::REG_KEY_HIGH: key_high_in = csr_data;
            default:                 key_low_in  = key_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   acorn_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .key_low        (key_low_ff),
      .key_high       (key_high_ff),
      .out_free       (out_free),
      .core_y         (core_y),
      .step_ctrl      (step_ctrl),
      .emit           (emit)
   );

   acorn_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_ctrl (step_ctrl),
      .y_byte    (core_y)
   );

   // Hold a result word until it is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit.word;
         rsp_tag_in   = emit.is_tag;
         rsp_last_in  = emit.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_word = rsp_word_ff;
   assign rsp_is_tag   = rsp_tag_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: hw/rtl/acorn_core.sv
// Cipher state shift register, advanced eight steps (one byte) per cycle while step is set.
module acorn_core (
   input  logic                      clock,
   input  logic                      reset,
   input  acorn_pkg::step_ctrl_type  step_ctrl,
   output logic [7:0]                y_byte
);

   logic [acorn_pkg::STATE_W-1:0] state_ff;
   logic [acorn_pkg::STATE_W-1:0] state_in;
   logic [acorn_pkg::STATE_W-1:0] stepped;

   // Run one byte of steps, least significant bit first
   always_comb begin
      logic [acorn_pkg::STATE_W-1:0] cur;
      acorn_pkg::step_result_type    res;
      cur = state_ff;
      y_byte = '0;
      for (int i = 0; i < 8; i++) begin
         res = acorn_pkg::acorn_step(cur, step_ctrl.x[i], step_ctrl.ca, step_ctrl.cb,
                                     step_ctrl.dec);
         cur = res.st;
         y_byte[i] = res.y;
      end
      stepped = cur;
   end

   // Clear on init start, advance on a step, hold otherwise
   always_comb begin
      if (step_ctrl.clear) begin
         state_in = '0;
      end else if (step_ctrl.step) begin
         state_in = stepped;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/acorn_ctrl.sv
// Command sequencer: iv collection, init, padding, data, tag phases and word assembly.
module acorn_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_command,
   input  logic [31:0]               req_data_word,
   input  logic [2:0]                req_byte_count,
   input  logic [63:0]               key_low,
   input  logic [63:0]               key_high,
   input  logic                      out_free,
   input  logic [7:0]                core_y,
   output acorn_pkg::step_ctrl_type  step_ctrl,
   output acorn_pkg::emit_type       emit
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_PAD  = 7'b0000100,
      ST_DATA = 7'b0001000,
      ST_MIX  = 7'b0010000,
      ST_TAG  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  iv_seen_ff, iv_seen_in;
   logic        started_ff, started_in;
   logic        is_ad_ff, is_ad_in;
   logic        is_dec_ff, is_dec_in;
   logic        is_fin_ff, is_fin_in;
   logic        pad_cb_ff, pad_cb_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] last_iv_ff, last_iv_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] iv_mem [3];

   logic        req_fire;
   logic [2:0]  req_cnt;
   logic        iv_write;
   logic [5:0]  init_word;
   logic [31:0] key_word;
   logic [31:0] iv_word;
   logic [31:0] init_src;
   logic [7:0]  cnt_last;
   logic        clear;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_cnt   = (req_byte_count > acorn_pkg::MAX_BYTES) ? acorn_pkg::MAX_BYTES
                                                              : req_byte_count;
   assign cnt_last  = {5'b0, cnt_ff - 3'd1};
   assign iv_write  = req_fire && (req_command == acorn_pkg::CMD_IV) && (iv_seen_ff != 2'd3);
   assign clear     = req_fire && (req_command == acorn_pkg::CMD_IV) && (iv_seen_ff == 2'd3);

   // Pick the init source word: key, stored iv, last iv, then key rounds
   assign init_word = byte_ff[7:2];
   always_comb begin
      unique case (init_word[1:0])
         2'd0:    key_word = key_low[31:0];
         2'd1:    key_word = key_low[63:32];
         2'd2:    key_word = key_high[31:0];
         default: key_word = key_high[63:32];
      endcase
      case (init_word[1:0])
         2'd0:    iv_word = iv_mem[0];
         2'd1:    iv_word = iv_mem[1];
         default: iv_word = iv_mem[2];
      endcase
      if (init_word >= 6'd4 && init_word <= 6'd6) begin
         init_src = iv_word;
      end else if (init_word == 6'd7) begin
         init_src = last_iv_ff;
      end else if (init_word == acorn_pkg::INIT_KEY_XOR) begin
         init_src = key_word ^ acorn_pkg::KEY_XOR_CONST;
      end else begin
         init_src = key_word;
      end
   end

   // Drive the core's per-byte inputs
   always_comb begin
      step_ctrl.clear = clear;
      step_ctrl.step  = 1'b0;
      step_ctrl.x     = '0;
      step_ctrl.ca    = 1'b1;
      step_ctrl.cb    = 1'b1;
      step_ctrl.dec   = 1'b0;
      unique case (state_ff) inside
         ST_INIT: begin
            step_ctrl.step = 1'b1;
            step_ctrl.x    = init_src[{byte_ff[1:0], 3'b000} +: 8];
         end
         ST_PAD: begin
            step_ctrl.step = 1'b1;
            step_ctrl.x    = (byte_ff == 8'd0) ? acorn_pkg::PAD_FIRST_BYTE : 8'h00;
            step_ctrl.ca   = (byte_ff < acorn_pkg::PAD_CA_BYTES);
            step_ctrl.cb   = pad_cb_ff;
         end
         ST_DATA: begin
            step_ctrl.step = 1'b1;
            step_ctrl.x    = word_ff[{byte_ff[1:0], 3'b000} +: 8];
            step_ctrl.cb   = is_ad_ff;
            step_ctrl.dec  = is_dec_ff;
         end
         ST_MIX, ST_TAG: begin
            step_ctrl.step = 1'b1;
         end
         ST_IDLE, ST_EMIT: begin
            step_ctrl.step = 1'b0;
         end
         default: begin
            step_ctrl.step = 1'b0;
         end
      endcase
   end

   // Result word toward the output register
   assign emit.load   = (state_ff == ST_EMIT) && out_free;
   assign emit.word   = acc_ff;
   assign emit.is_tag = is_fin_ff;
   assign emit.last   = !is_fin_ff || (byte_ff == acorn_pkg::TAG_DONE);

   // Sequence the phases
   always_comb begin
      state_in   = state_ff;
      byte_in    = byte_ff;
      iv_seen_in = iv_seen_ff;
      started_in = started_ff;
      is_ad_in   = is_ad_ff;
      is_dec_in  = is_dec_ff;
      is_fin_in  = is_fin_ff;
      pad_cb_in  = pad_cb_ff;
      cnt_in     = cnt_ff;
      word_in    = word_ff;
      last_iv_in = last_iv_ff;
      acc_in     = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               word_in = req_data_word;
               cnt_in  = req_cnt;
               byte_in = 8'd0;
               unique case (req_command) inside
                  acorn_pkg::CMD_IV: begin
                     if (iv_seen_ff == 2'd3) begin
                        iv_seen_in = 2'd0;
                        started_in = 1'b0;
                        last_iv_in = req_data_word;
                        state_in   = ST_INIT;
                     end else begin
                        iv_seen_in = iv_seen_ff + 2'd1;
                     end
                  end
                  acorn_pkg::CMD_AD: begin
                     is_ad_in  = 1'b1;
                     is_dec_in = 1'b0;
                     is_fin_in = 1'b0;
                     if (!started_ff && req_cnt != 3'd0) begin
                        state_in = ST_DATA;
                     end
                  end
                  acorn_pkg::CMD_ENC, acorn_pkg::CMD_DEC: begin
                     is_ad_in  = 1'b0;
                     is_dec_in = (req_command == acorn_pkg::CMD_DEC);
                     is_fin_in = 1'b0;
                     acc_in    = '0;
                     if (!started_ff) begin
                        started_in = 1'b1;
                        pad_cb_in  = 1'b1;
                        state_in   = ST_PAD;
                     end else if (req_cnt != 3'd0) begin
                        state_in = ST_DATA;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  acorn_pkg::CMD_FIN: begin
                     is_ad_in  = 1'b0;
                     is_dec_in = 1'b0;
                     is_fin_in = 1'b1;
                     pad_cb_in = !started_ff;
                     state_in  = ST_PAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INIT: begin
            if (byte_ff == acorn_pkg::INIT_LAST) begin
               byte_in  = 8'd0;
               state_in = ST_IDLE;
            end else begin
               byte_in = byte_ff + 8'd1;
            end
         end
         ST_PAD: begin
            if (byte_ff == acorn_pkg::PAD_LAST) begin
               byte_in = 8'd0;
               if (is_fin_ff && pad_cb_ff) begin
                  pad_cb_in = 1'b0;
               end else if (is_fin_ff) begin
                  state_in = ST_MIX;
               end else if (cnt_ff != 3'd0) begin
                  state_in = ST_DATA;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               byte_in = byte_ff + 8'd1;
            end
         end
         ST_DATA: begin
            acc_in[{byte_ff[1:0], 3'b000} +: 8] = core_y;
            if (byte_ff == cnt_last) begin
               byte_in  = 8'd0;
               state_in = is_ad_ff ? ST_IDLE : ST_EMIT;
            end else begin
               byte_in = byte_ff + 8'd1;
            end
         end
         ST_MIX: begin
            if (byte_ff == acorn_pkg::MIX_LAST) begin
               byte_in  = 8'd0;
               state_in = ST_TAG;
            end else begin
               byte_in = byte_ff + 8'd1;
            end
         end
         ST_TAG: begin
            acc_in[{byte_ff[1:0], 3'b000} +: 8] = core_y;
            byte_in = byte_ff + 8'd1;
            if (byte_ff[1:0] == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (is_fin_ff && byte_ff != acorn_pkg::TAG_DONE) begin
                  state_in = ST_TAG;
               end else begin
                  byte_in  = 8'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         byte_ff    <= '0;
         iv_seen_ff <= '0;
         started_ff <= 1'b0;
         is_ad_ff   <= 1'b0;
         is_dec_ff  <= 1'b0;
         is_fin_ff  <= 1'b0;
         pad_cb_ff  <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         byte_ff    <= byte_in;
         iv_seen_ff <= iv_seen_in;
         started_ff <= started_in;
         is_ad_ff   <= is_ad_in;
         is_dec_ff  <= is_dec_in;
         is_fin_ff  <= is_fin_in;
         pad_cb_ff  <= pad_cb_in;
         cnt_ff     <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      last_iv_ff <= last_iv_in;
      acc_ff     <= acc_in;
   end

   // Store the first three iv words
   always_ff @(posedge clock) begin
      if (iv_write) begin
         iv_mem[iv_seen_ff] <= req_data_word;
      end
   end

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      step_ctrl.step |-> !(state_ff == ST_IDLE || state_ff == ST_EMIT))
      else $error("state stepped while idle or emitting");

   a_clear_on_iv: assert property (@(posedge clock) disable iff (reset)
      step_ctrl.clear |-> (req_fire && req_command == acorn_pkg::CMD_IV && iv_seen_ff == 2'd3))
      else $error("state cleared outside the fourth iv word");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> (out_free && state_ff == ST_EMIT))
      else $error("result loaded into a busy output register");

   a_start_on_data: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> ($past(req_fire) && ($past(req_command) == acorn_pkg::CMD_ENC ||
                                                  $past(req_command) == acorn_pkg::CMD_DEC)))
      else $error("data phase started without a data word");

endmodule
